>>> rtl/u2u_pkg.sv
// Shared types, constants and the lead-byte classifier for the UTF-8 to UTF-16 transcoder.
// No dependencies. Every other rtl file refers to this package by scoped names.
package u2u_pkg;

  localparam int UNITS_MAX = 4;

  localparam logic [15:0] SUB_UNIT     = 16'h003F;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  typedef enum logic [2:0] {
    KIND_CONT  = 3'd0,
    KIND_ASCII = 3'd1,
    KIND_LEAD2 = 3'd2,
    KIND_LEAD3 = 3'd3,
    KIND_LEAD4 = 3'd4,
    KIND_BAD   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [1:0]  needed;
    logic [1:0]  taken;
    logic [20:0] cp;
  } seq_t;

  typedef struct packed {
    logic [UNITS_MAX-1:0][15:0] unit;
    logic [UNITS_MAX-1:0]       sub;
    logic [2:0]                 count;
    logic                       fin;
  } bundle_t;

  function automatic kind_t byte_kind(input logic [4:0] top5);
    kind_t k;
    unique case (top5) inside
      [5'd0:5'd15]:  k = KIND_ASCII;
      [5'd16:5'd23]: k = KIND_CONT;
      [5'd24:5'd27]: k = KIND_LEAD2;
      [5'd28:5'd29]: k = KIND_LEAD3;
      5'd30:         k = KIND_LEAD4;
      default:       k = KIND_BAD;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/u2u_decode.sv
// Per-byte decode: sequence state and one byte in, next state and a bundle of code units out.
// Depends on u2u_pkg.
module u2u_decode (
  input  logic [7:0]       data,
  input  logic             fin,
  input  u2u_pkg::seq_t    seq,
  output u2u_pkg::seq_t    seq_nxt,
  output u2u_pkg::bundle_t bundle
);

  u2u_pkg::kind_t kind;
  logic           pending;
  logic           is_cont;
  logic           complete;
  logic           flush;
  logic [1:0]     taken_inc;
  logic [1:0]     taken_eff;
  logic [1:0]     flush_n;
  logic [1:0]     tail_n;
  logic [1:0]     idx;
  logic [20:0]    cp_cat;
  logic [20:0]    cp_v;
  logic [15:0]    tail0;
  logic [15:0]    tail1;
  logic           tail_sub0;

  always_comb begin
    kind      = u2u_pkg::byte_kind(data[7:3]);
    pending   = seq.needed != 2'd0;
    is_cont   = kind == u2u_pkg::KIND_CONT;
    taken_inc = seq.taken + 2'd1;
    cp_cat    = {seq.cp[14:0], data[5:0]};
    cp_v      = cp_cat - u2u_pkg::SUPP_BASE;
    complete  = pending && is_cont && (taken_inc == seq.needed);
    flush     = pending && (!is_cont || (!complete && fin));
    taken_eff = is_cont ? taken_inc : seq.taken;
    flush_n   = flush ? 2'(taken_eff + 2'd1) : 2'd0;

    tail0     = u2u_pkg::SUB_UNIT;
    tail1     = u2u_pkg::SUB_UNIT;
    tail_sub0 = 1'b0;
    tail_n    = 2'd0;
    seq_nxt   = '0;

    if (pending && is_cont) begin
      if (complete) begin
        if (cp_cat[20:16] == 5'd0) begin
          tail0  = cp_cat[15:0];
          tail_n = 2'd1;
        end else begin
          tail0  = u2u_pkg::HI_SURR_BASE + {5'd0, cp_v[20:10]};
          tail1  = u2u_pkg::LO_SURR_BASE | {6'd0, cp_v[9:0]};
          tail_n = 2'd2;
        end
      end else if (!fin) begin
        seq_nxt.needed = seq.needed;
        seq_nxt.taken  = taken_inc;
        seq_nxt.cp     = cp_cat;
      end
    end else begin
      case (kind) inside
        u2u_pkg::KIND_ASCII: begin
          tail0  = {8'd0, data};
          tail_n = 2'd1;
        end
        u2u_pkg::KIND_LEAD2, u2u_pkg::KIND_LEAD3, u2u_pkg::KIND_LEAD4: begin
          if (fin) begin
            tail_sub0 = 1'b1;
            tail_n    = 2'd1;
          end else begin
            case (kind)
              u2u_pkg::KIND_LEAD2: begin
                seq_nxt.needed = 2'd1;
                seq_nxt.cp     = {16'd0, data[4:0]};
              end
              u2u_pkg::KIND_LEAD3: begin
                seq_nxt.needed = 2'd2;
                seq_nxt.cp     = {17'd0, data[3:0]};
              end
              default: begin
                seq_nxt.needed = 2'd3;
                seq_nxt.cp     = {18'd0, data[2:0]};
              end
            endcase
          end
        end
        default: begin
          tail_sub0 = 1'b1;
          tail_n    = 2'd1;
        end
      endcase
    end

    bundle.fin   = fin;
    bundle.count = {1'b0, flush_n} + {1'b0, tail_n};
    for (int i = 0; i < u2u_pkg::UNITS_MAX; i++) begin
      idx = 2'(i) - flush_n;
      if (3'(i) < {1'b0, flush_n}) begin
        bundle.unit[i] = u2u_pkg::SUB_UNIT;
        bundle.sub[i]  = 1'b1;
      end else if (idx == 2'd0) begin
        bundle.unit[i] = tail0;
        bundle.sub[i]  = tail_sub0;
      end else begin
        bundle.unit[i] = tail1;
        bundle.sub[i]  = 1'b0;
      end
    end
  end

endmodule

>>> rtl/u2u_serial.sv
// Bundle buffer and output register: sends a bundle's code units one transfer at a time.
// Depends on u2u_pkg.
module u2u_serial (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  u2u_pkg::bundle_t bundle,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [15:0]      out_code_unit,
  output logic             out_is_substitute,
  output logic             out_run_last,
  output logic             out_stream_last
);

  u2u_pkg::bundle_t b_r, b_nxt;
  logic             b_valid_r, b_valid_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic             o_valid_r, o_valid_nxt;
  logic [15:0]      o_unit_r, o_unit_nxt;
  logic             o_sub_r, o_sub_nxt;
  logic             o_run_r, o_run_nxt;
  logic             o_end_r, o_end_nxt;
  logic             o_load;
  logic             b_last;
  logic             b_leave;

  always_comb begin
    o_load  = !o_valid_r || !out_stall;
    b_last  = {1'b0, pos_r} == 3'(b_r.count - 3'd1);
    b_leave = b_valid_r && o_load && b_last;
    busy    = b_valid_r && !b_leave;

    o_valid_nxt = o_valid_r;
    o_unit_nxt  = o_unit_r;
    o_sub_nxt   = o_sub_r;
    o_run_nxt   = o_run_r;
    o_end_nxt   = o_end_r;
    if (o_load) begin
      o_valid_nxt = b_valid_r;
      o_unit_nxt  = b_r.unit[pos_r];
      o_sub_nxt   = b_r.sub[pos_r];
      o_run_nxt   = b_last;
      o_end_nxt   = b_last && b_r.fin;
    end

    b_valid_nxt = b_valid_r;
    b_nxt       = b_r;
    pos_nxt     = pos_r;
    if (b_valid_r && o_load) begin
      if (b_last) begin
        b_valid_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
    if (load) begin
      b_valid_nxt = 1'b1;
      b_nxt       = bundle;
      pos_nxt     = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      pos_r     <= 2'd0;
      o_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      pos_r     <= pos_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r      <= b_nxt;
    o_unit_r <= o_unit_nxt;
    o_sub_r  <= o_sub_nxt;
    o_run_r  <= o_run_nxt;
    o_end_r  <= o_end_nxt;
  end

  assign out_valid         = o_valid_r;
  assign out_code_unit     = o_unit_r;
  assign out_is_substitute = o_sub_r;
  assign out_run_last      = o_run_r;
  assign out_stream_last   = o_end_r;

  a_bundle_count: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_r.count != 3'd0) && ({1'b0, pos_r} < b_r.count))
    else $error("bundle buffer holds an empty bundle or runs past its count");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!b_valid_r || b_leave))
    else $error("bundle loaded over one still in flight");

  a_stream_last: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_end_r) |-> o_run_r)
    else $error("stream_last without run_last");

  a_substitute: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_sub_r) |-> (o_unit_r == u2u_pkg::SUB_UNIT))
    else $error("substitute flag on a unit that is not the replacement");

endmodule

>>> rtl/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder: sequence state, decode and output serializer.
// Depends on u2u_pkg, u2u_decode and u2u_serial.
//
// Input channel: one UTF-8 byte per transfer (in_byte), with in_stream_end set on the
// final byte of a stream. Output channel: one UTF-16 code unit per transfer, with
// out_is_substitute on '?' replacements, out_run_last on the last unit caused by an input
// byte and out_stream_last on the last unit of a stream.
// A byte is decoded in the cycle it is accepted and its zero to four units are held in a
// bundle buffer, which feeds the output register one unit per cycle while the receiver
// does not stall. An accepted byte's first unit goes through the bundle buffer and then the
// output register. Throughput: one byte per cycle while each byte yields at most one
// unit and the receiver does not stall; a byte with more units holds the buffer until its
// last unit moves on, so a surrogate pair or a flush of a broken sequence holds up the input.
// Reset (rst_n low, synchronous) drops any pending sequence and any buffered units.
// When the receiver stalls, the output register holds its unit, the bundle buffer holds
// the next bundle, and in_stall rises once the buffer cannot drain.
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_is_substitute,
  output logic        out_run_last,
  output logic        out_stream_last
);

  u2u_pkg::seq_t    seq_r, seq_nxt, seq_dec;
  u2u_pkg::bundle_t bundle;
  logic             accept;
  logic             busy;
  logic             load;

  u2u_decode u_decode (
    .data    (in_byte),
    .fin     (in_stream_end),
    .seq     (seq_r),
    .seq_nxt (seq_dec),
    .bundle  (bundle)
  );

  always_comb begin
    accept  = in_valid && !busy;
    load    = accept && (bundle.count != 3'd0);
    seq_nxt = accept ? seq_dec : seq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  u2u_serial u_serial (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (load),
    .bundle            (bundle),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_code_unit     (out_code_unit),
    .out_is_substitute (out_is_substitute),
    .out_run_last      (out_run_last),
    .out_stream_last   (out_stream_last)
  );

  assign in_stall = busy;

  a_taken_below_needed: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r.needed != 2'd0) |-> (seq_r.taken < seq_r.needed))
    else $error("continuation count reached the sequence length without completing");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r.needed == 2'd0) |-> (seq_r.taken == 2'd0 && seq_r.cp == 21'd0))
    else $error("idle sequence state not cleared");

  a_end_output: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_stream_end) |-> load)
    else $error("stream end accepted without any unit");

endmodule
